### src/lz2d_pkg.sv
// lz2d_pkg: shared constants and types for the 2-D offset LZ image decoder.
// No dependencies; imported by every module of the block.

package lz2d_pkg;

    // default history window (entries of 8 bits)
    localparam int WINDOW_DEPTH_DEF = 4096;

    // front-to-back queue depth
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    // input item kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // stream codes
    localparam logic [7:0]  LONG_LIT_FLAG  = 8'h7F;
    localparam logic [2:0]  LONG_COPY_CODE = 3'd7;
    localparam logic [16:0] COPY_SIZE_BIAS = 17'd3;
    localparam logic [16:0] LIT_SIZE_BIAS  = 17'd1;
    localparam logic [16:0] LEN_BIAS_COPY  = 17'h0A;
    localparam logic [16:0] LEN_BIAS_LIT   = 17'h80;

    // register defaults
    localparam logic [10:0] WIDTH_RST = 11'd640;
    localparam logic [31:0] COUNT_RST = 32'd307200;

    // control bits of one queued pixel operation
    typedef struct packed {
        logic is_copy;   // pixel comes from history
        logic is_err;    // bad back-reference result, pixel 0
        logic last;      // ends the frame
    } op_ctrl_t;

endpackage

### src/lz_2d_offset_image_decompressor.sv
// lz_2d_offset_image_decompressor: top level, register port plus
// parser -> queue -> history/result stage. Uses lz2d_pkg and all lz2d_* modules.
//
//  channel   direction  handshake                 payload
//  s_        in         s_valid / s_ready         s_kind, s_data_byte
//  m_        out        m_valid / m_ready         m_pixel, m_last_pixel, m_bad_reference
//  apb       in         psel/penable/pwrite       paddr, pwdata -> prdata (pready tied high)
//
// One item per cycle sustained while m_ready keeps the result register free. An
// accepted item goes parser -> queue, then is popped into the result register,
// which offers it and can hand it on while the output side is free.
// The history memory has one write and one registered read port.
// aresetn is synchronous, active low; history contents are not cleared.
// m_ready low stalls the result register, the queue then fills and s_ready drops.

module lz_2d_offset_image_decompressor
    import lz2d_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_data_byte,
    // pixel output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel,
    output logic        m_last_pixel,
    output logic        m_bad_reference,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CTRL_W = $bits(op_ctrl_t);
    localparam int OP_W   = CTRL_W + 8 + 2 * ADDR_W;

    // register index is paddr[2]: 0 width, 1 pixel count
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    logic [10:0] image_width_reg;
    logic [31:0] pixel_count_reg;
    logic        cfg_wr;

    // parser side of the queue
    logic              f_valid, f_ready;
    op_ctrl_t          f_ctrl;
    logic [7:0]        f_data;
    logic [ADDR_W-1:0] f_src, f_waddr;
    logic [OP_W-1:0]   f_pack;

    // history side of the queue
    logic              q_valid, q_ready;
    logic [OP_W-1:0]   q_pack;
    op_ctrl_t          q_ctrl;
    logic [7:0]        q_data;
    logic [ADDR_W-1:0] q_src, q_waddr;

    // register port: writes land on the access cycle, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_WIDTH) ? {21'd0, image_width_reg} : pixel_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= WIDTH_RST;
            pixel_count_reg <= COUNT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH: image_width_reg <= pwdata[10:0];
                REG_COUNT: pixel_count_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    lz2d_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .kind        (s_kind),
        .data_byte   (s_data_byte),
        .image_width (image_width_reg),
        .pixel_count (pixel_count_reg),
        .op_valid    (f_valid),
        .op_ready    (f_ready),
        .op_ctrl     (f_ctrl),
        .op_data     (f_data),
        .op_src      (f_src),
        .op_waddr    (f_waddr)
    );

    assign f_pack = {f_ctrl, f_data, f_src, f_waddr};

    lz2d_queue #(
        .DATA_W (OP_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_pack),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_pack)
    );

    assign {q_ctrl, q_data, q_src, q_waddr} = q_pack;

    lz2d_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op_valid        (q_valid),
        .op_ready        (q_ready),
        .op_ctrl         (q_ctrl),
        .op_data         (q_data),
        .op_src          (q_src),
        .op_waddr        (q_waddr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel         (m_pixel),
        .m_last_pixel    (m_last_pixel),
        .m_bad_reference (m_bad_reference)
    );

endmodule

### src/lz2d_front.sv
// lz2d_front: stream parser. Accepts items, tracks run state and position,
// emits one pixel operation per result into the queue. Uses lz2d_pkg.

module lz2d_front
    import lz2d_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(WINDOW_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [7:0]        data_byte,
    input  logic [10:0]       image_width,
    input  logic [31:0]       pixel_count,
    output logic              op_valid,
    input  logic              op_ready,
    output op_ctrl_t          op_ctrl,
    output logic [7:0]        op_data,
    output logic [ADDR_W-1:0] op_src,
    output logic [ADDR_W-1:0] op_waddr
);

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_FLAG    = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;
    localparam logic [2:0] PH_COPY    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic signed [33:0] DEPTH_34 = 34'(WINDOW_DEPTH);
    localparam logic signed [ADDR_W+1:0] DEPTH_X = (ADDR_W+2)'(WINDOW_DEPTH);

    logic [2:0]        phase_reg, phase_next;
    logic [31:0]       pixels_done_reg, pixels_done_next;
    logic [ADDR_W-1:0] wpos_reg, wpos_next;
    logic              run_is_copy_reg, run_is_copy_next;
    logic [16:0]       run_remaining_reg, run_remaining_next;
    logic [3:0]        lookback_select_reg, lookback_select_next;
    logic [7:0]        length_low_byte_reg, length_low_byte_next;
    logic [ADDR_W-1:0] copy_src_reg, copy_src_next;

    logic accept;
    logic do_put;
    logic [7:0] put_data;
    logic put_copy;

    // run start inputs (flag phase uses the byte, length phase the saved fields)
    logic              cur_copy;
    logic [3:0]        cur_sel;
    logic [16:0]       flag_size, len_size, cur_size;
    logic signed [13:0] w14, sel14, lb_dist;
    logic signed [33:0] dist34, pd34, end34, pc34;
    logic              bad_ref;
    logic signed [ADDR_W+1:0] src_diff;
    logic [ADDR_W-1:0] src_start;

    // pixel bookkeeping
    logic [32:0] pd_inc;
    logic        put_last;
    logic [16:0] rr_base, rr_after;
    logic [ADDR_W-1:0] wpos_inc, copy_src_inc;

    assign in_ready = op_ready;
    assign accept   = in_valid && in_ready;

    assign flag_size = data_byte[7] ? (17'(data_byte[2:0]) + COPY_SIZE_BIAS)
                                    : (17'(data_byte) + LIT_SIZE_BIAS);
    assign len_size  = {1'b0, data_byte, length_low_byte_reg}
                     + (run_is_copy_reg ? LEN_BIAS_COPY : LEN_BIAS_LIT);
    assign cur_copy  = (phase_reg == PH_FLAG) ? data_byte[7]   : run_is_copy_reg;
    assign cur_sel   = (phase_reg == PH_FLAG) ? data_byte[6:3] : lookback_select_reg;
    assign cur_size  = (phase_reg == PH_FLAG) ? flag_size      : len_size;

    // lookback distance: 1..4, width-3..width+3, 2*width-2..2*width+2
    assign w14   = $signed({3'b000, image_width});
    assign sel14 = $signed({10'd0, cur_sel});
    always_comb begin
        if (cur_sel < 4'd4) begin
            lb_dist = sel14 + 14'sd1;
        end else if (cur_sel < 4'd11) begin
            lb_dist = w14 + sel14 - 14'sd7;
        end else begin
            lb_dist = w14 + w14 + sel14 - 14'sd13;
        end
    end

    assign dist34 = 34'(lb_dist);
    assign pd34   = $signed({2'b00, pixels_done_reg});
    assign pc34   = $signed({2'b00, pixel_count});
    assign end34  = pd34 - dist34 + $signed({17'd0, cur_size});
    assign bad_ref = (dist34 < 34'sd1) || (dist34 > pd34) || (dist34 > DEPTH_34)
                  || (end34 > pc34);

    // source position modulo the window
    assign src_diff  = $signed({2'b00, wpos_reg}) - $signed(dist34[ADDR_W+1:0]);
    assign src_start = (src_diff < 0) ? ADDR_W'(src_diff + DEPTH_X)
                                      : src_diff[ADDR_W-1:0];

    assign wpos_inc     = (wpos_reg == ADDR_LAST) ? '0 : wpos_reg + 1'b1;
    assign copy_src_inc = (copy_src_reg == ADDR_LAST) ? '0 : copy_src_reg + 1'b1;
    assign pd_inc       = {1'b0, pixels_done_reg} + 33'd1;
    assign put_last     = pd_inc >= {1'b0, pixel_count};
    assign rr_base      = (phase_reg == PH_FIRST) ? 17'd1 : run_remaining_reg;
    assign rr_after     = (rr_base != 17'd0) ? rr_base - 17'd1 : rr_base;

    always_comb begin
        phase_next           = phase_reg;
        pixels_done_next     = pixels_done_reg;
        wpos_next            = wpos_reg;
        run_is_copy_next     = run_is_copy_reg;
        run_remaining_next   = run_remaining_reg;
        lookback_select_next = lookback_select_reg;
        length_low_byte_next = length_low_byte_reg;
        copy_src_next        = copy_src_reg;
        do_put   = 1'b0;
        put_copy = 1'b0;
        put_data = data_byte;
        op_valid = 1'b0;
        op_ctrl  = '0;
        op_data  = data_byte;
        op_src   = copy_src_reg;
        op_waddr = wpos_reg;

        if (accept) begin
            case (kind)
                KIND_START: begin
                    phase_next           = PH_FIRST;
                    pixels_done_next     = '0;
                    wpos_next            = '0;
                    run_is_copy_next     = 1'b0;
                    run_remaining_next   = '0;
                    lookback_select_next = '0;
                    length_low_byte_next = '0;
                    copy_src_next        = '0;
                end
                KIND_TICK: begin
                    if (phase_reg == PH_COPY) begin
                        do_put        = 1'b1;
                        put_copy      = 1'b1;
                        copy_src_next = copy_src_inc;
                    end
                end
                KIND_BYTE: begin
                    case (phase_reg)
                        PH_FIRST: begin
                            if (pixel_count != 32'd0) begin
                                do_put = 1'b1;
                            end
                        end
                        PH_LITERAL: begin
                            do_put = 1'b1;
                        end
                        PH_LEN_LO: begin
                            length_low_byte_next = data_byte;
                            phase_next           = PH_LEN_HI;
                        end
                        PH_FLAG, PH_LEN_HI: begin
                            if (phase_reg == PH_FLAG) begin
                                run_is_copy_next = data_byte[7];
                                if (data_byte[7]) begin
                                    lookback_select_next = data_byte[6:3];
                                end
                            end
                            if (phase_reg == PH_FLAG
                                && ((data_byte[7] && data_byte[2:0] == LONG_COPY_CODE)
                                    || data_byte == LONG_LIT_FLAG)) begin
                                phase_next = PH_LEN_LO;
                            end else begin
                                run_remaining_next = cur_size;
                                if (!cur_copy) begin
                                    phase_next = PH_LITERAL;
                                end else if (bad_ref) begin
                                    op_valid           = 1'b1;
                                    op_ctrl.is_err     = 1'b1;
                                    op_ctrl.last       = 1'b1;
                                    run_remaining_next = '0;
                                    phase_next         = PH_DONE;
                                end else begin
                                    copy_src_next = src_start;
                                    phase_next    = PH_COPY;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase

            if (do_put) begin
                op_valid           = 1'b1;
                op_ctrl.is_copy    = put_copy;
                op_ctrl.last       = put_last;
                op_data            = put_data;
                pixels_done_next   = pd_inc[31:0];
                wpos_next          = wpos_inc;
                run_remaining_next = rr_after;
                if (put_last) begin
                    phase_next = PH_DONE;
                end else if (rr_after == 17'd0) begin
                    phase_next = PH_FLAG;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_FIRST;
            pixels_done_reg     <= '0;
            wpos_reg            <= '0;
            run_is_copy_reg     <= 1'b0;
            run_remaining_reg   <= '0;
            lookback_select_reg <= '0;
            length_low_byte_reg <= '0;
            copy_src_reg        <= '0;
        end else begin
            phase_reg           <= phase_next;
            pixels_done_reg     <= pixels_done_next;
            wpos_reg            <= wpos_next;
            run_is_copy_reg     <= run_is_copy_next;
            run_remaining_reg   <= run_remaining_next;
            lookback_select_reg <= lookback_select_next;
            length_low_byte_reg <= length_low_byte_next;
            copy_src_reg        <= copy_src_next;
        end
    end

endmodule

### src/lz2d_queue.sv
// lz2d_queue: small FIFO between parser and history stage.
// Uses lz2d_pkg for depth and pointer widths.

module lz2d_queue
    import lz2d_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(Q_DEPTH - 1);

    logic [DATA_W-1:0] slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign wr_ready = count_reg != QCNT_W'(Q_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/lz2d_back.sv
// lz2d_back: history window and result register. Reads the copy source on
// pop, writes each non-error pixel when its result transfers. Uses lz2d_pkg.

module lz2d_back
    import lz2d_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(WINDOW_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              op_valid,
    output logic              op_ready,
    input  op_ctrl_t          op_ctrl,
    input  logic [7:0]        op_data,
    input  logic [ADDR_W-1:0] op_src,
    input  logic [ADDR_W-1:0] op_waddr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_pixel,
    output logic              m_last_pixel,
    output logic              m_bad_reference
);

    logic [7:0] history [WINDOW_DEPTH];

    logic              b_valid_reg;
    op_ctrl_t          b_ctrl_reg;
    logic [7:0]        b_data_reg;
    logic [ADDR_W-1:0] b_src_reg;
    logic [ADDR_W-1:0] b_waddr_reg;
    logic [7:0]        rdata_reg;

    // most recent history write, covers a read issued in the same cycle
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [7:0]        lw_data_reg;

    logic pop, done, wr_en, fwd;
    logic [7:0] pixel_b;

    assign op_ready = !b_valid_reg || m_ready;
    assign pop      = op_valid && op_ready;
    assign done     = b_valid_reg && m_ready;
    assign wr_en    = done && !b_ctrl_reg.is_err;
    assign fwd      = lw_valid_reg && (lw_addr_reg == b_src_reg);

    always_comb begin
        if (b_ctrl_reg.is_err) begin
            pixel_b = 8'd0;
        end else if (b_ctrl_reg.is_copy) begin
            pixel_b = fwd ? lw_data_reg : rdata_reg;
        end else begin
            pixel_b = b_data_reg;
        end
    end

    assign m_valid         = b_valid_reg;
    assign m_pixel         = pixel_b;
    assign m_last_pixel    = b_ctrl_reg.last;
    assign m_bad_reference = b_ctrl_reg.is_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            b_ctrl_reg   <= '0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                b_valid_reg <= 1'b1;
                b_ctrl_reg  <= op_ctrl;
            end else if (done) begin
                b_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b_data_reg  <= op_data;
            b_src_reg   <= op_src;
            b_waddr_reg <= op_waddr;
        end
        if (wr_en) begin
            lw_addr_reg <= b_waddr_reg;
            lw_data_reg <= pixel_b;
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            history[b_waddr_reg] <= pixel_b;
        end
        if (pop) begin
            rdata_reg <= history[op_src];
        end
    end

endmodule

### verif/lz_2d_offset_image_decompressor_test.sv
// lz_2d_offset_image_decompressor_test: self-checking bench for the 2-D offset LZ image
// decoder. Needs lz2d_pkg and lz_2d_offset_image_decompressor; nothing else.

module lz_2d_offset_image_decompressor_test
    import lz2d_pkg::*;
();

    // register map: index i sits at byte address 4*i
    localparam int REG_IMAGE_WIDTH = 0;
    localparam int REG_PIXEL_COUNT = 1;

    // kind 3 has no meaning; the block must drop it
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // result path is parser -> queue -> result register, which DRAIN_CYCLES covers
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 40;

    // receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;

    typedef enum logic [2:0] {
        AWAIT_RAW, AWAIT_FLAG, AWAIT_LEN_LO, AWAIT_LEN_HI, IN_LITERAL, IN_COPY, FRAME_DONE
    } parse_phase_e;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       bad;
    } pixel_result_t;

    // Tracks the decoder state per accepted transfer and holds the pixels still owed.
    class pixel_scoreboard;
        bit [7:0]      history [WINDOW_DEPTH_DEF];
        bit [31:0]     pixels_done;
        parse_phase_e  phase;
        bit            run_is_copy;
        bit [16:0]     run_left;
        bit [3:0]      lookback;
        bit [7:0]      len_low;
        bit [31:0]     copy_src;
        bit [10:0]     image_width;
        bit [31:0]     pixel_count;
        pixel_result_t awaited_pixels[$];
        int            mismatches;

        function new();
            image_width = WIDTH_RST;
            pixel_count = COUNT_RST;
            mismatches  = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            pixels_done = 0;
            phase       = AWAIT_RAW;
            run_is_copy = 0;
            run_left    = 0;
            lookback    = 0;
            len_low     = 0;
            copy_src    = 0;
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            if (idx == REG_IMAGE_WIDTH) begin
                image_width = value[10:0];
            end else if (idx == REG_PIXEL_COUNT) begin
                pixel_count = value;
            end
        endfunction

        // appends one owed result at the tail
        function void owe_result(pixel_result_t r);
            awaited_pixels = {awaited_pixels, r};
        endfunction

        function void emit_pixel(bit [7:0] v);
            pixel_result_t r;
            history[pixels_done % WINDOW_DEPTH_DEF] = v;
            pixels_done++;
            if (run_left != 0) run_left--;
            r = '{pixel: v, last: 1'b0, bad: 1'b0};
            if (pixels_done >= pixel_count) begin
                r.last = 1'b1;
                phase  = FRAME_DONE;
            end else if (run_left == 0) begin
                phase = AWAIT_FLAG;
            end
            owe_result(r);
        endfunction

        function void open_run(int unsigned size);
            longint lookback_dist;
            run_left = size[16:0];
            if (!run_is_copy) begin
                phase = IN_LITERAL;
                return;
            end
            if (lookback < 4) begin
                lookback_dist = longint'(lookback) + 1;
            end else if (lookback < 11) begin
                lookback_dist = longint'(image_width) - 3 + (longint'(lookback) - 4);
            end else begin
                lookback_dist = 2 * longint'(image_width) - 2 + (longint'(lookback) - 11);
            end
            if (lookback_dist < 1 || lookback_dist > longint'(pixels_done)
                    || lookback_dist > WINDOW_DEPTH_DEF
                    || longint'(pixels_done) - lookback_dist + longint'(size)
                       > longint'(pixel_count)) begin
                owe_result('{pixel: 8'h00, last: 1'b1, bad: 1'b1});
                run_left = 0;
                phase    = FRAME_DONE;
            end else begin
                copy_src = pixels_done - lookback_dist[31:0];
                phase    = IN_COPY;
            end
        endfunction

        function void take_item(logic [1:0] kind, logic [7:0] b);
            bit [7:0] v;
            case (kind)
                KIND_START: restart_frame();
                KIND_TICK: begin
                    if (phase == IN_COPY) begin
                        v = history[copy_src % WINDOW_DEPTH_DEF];
                        copy_src++;
                        emit_pixel(v);
                    end
                end
                KIND_BYTE: begin
                    case (phase)
                        AWAIT_RAW: begin
                            if (pixel_count != 0) begin
                                run_left = 1;
                                emit_pixel(b);
                            end
                        end
                        AWAIT_FLAG: begin
                            if (b[7]) begin
                                run_is_copy = 1;
                                lookback    = b[6:3];
                                if (b[2:0] == LONG_COPY_CODE) begin
                                    phase = AWAIT_LEN_LO;
                                end else begin
                                    open_run(b[2:0] + COPY_SIZE_BIAS);
                                end
                            end else begin
                                run_is_copy = 0;
                                if (b == LONG_LIT_FLAG) begin
                                    phase = AWAIT_LEN_LO;
                                end else begin
                                    open_run(b + LIT_SIZE_BIAS);
                                end
                            end
                        end
                        AWAIT_LEN_LO: begin
                            len_low = b;
                            phase   = AWAIT_LEN_HI;
                        end
                        AWAIT_LEN_HI: begin
                            open_run({b, len_low} + (run_is_copy ? LEN_BIAS_COPY : LEN_BIAS_LIT));
                        end
                        IN_LITERAL: emit_pixel(b);
                        default: ;  // bytes during a copy or after the frame are dropped
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [7:0] px, logic last, logic bad);
            pixel_result_t want;
            if (awaited_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %02h last %0b bad %0b", $time, px, last, bad);
                mismatches++;
                return;
            end
            want = awaited_pixels.pop_front();
            if (px !== want.pixel) begin
                $display("%0t: pixel expected %02h actual %02h", $time, want.pixel, px);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last_pixel expected %0b actual %0b", $time, want.last, last);
                mismatches++;
            end
            if (bad !== want.bad) begin
                $display("%0t: bad_reference expected %0b actual %0b", $time, want.bad, bad);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_pixel;
    logic        m_last_pixel;
    logic        m_bad_reference;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard sb = new();

    int burst_left;     // transfers left in the current sender burst
    int items_sent;     // accepted input transfers so far
    bit hold_req;       // asks the receiver for one long hold-off

    lz_2d_offset_image_decompressor u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel         (m_pixel),
        .m_last_pixel    (m_last_pixel),
        .m_bad_reference (m_bad_reference),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #2000000;
        $display("lz_2d_offset_image_decompressor_test: done, errors");
        $finish;
    end

    // Output monitor: every result transfer is checked against the oldest owed pixel.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pixel(m_pixel, m_last_pixel, m_bad_reference);
        end
    end

    // Receiver: switches among stall patterns, including stretches with no stall at all.
    // On request it holds off for a long stretch so the internal queue fills and
    // s_ready has to drop while the sender keeps offering.
    initial begin
        int mode;
        int span;
        m_ready <= 1'b0;
        mode = RX_FREE;
        span = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(RX_FREE, RX_SPARSE);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    RX_FREE: m_ready <= 1'b1;
                    RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // One input transfer. Bursts of random length with random gaps in between;
    // valid stays high across back-to-back transfers and is only dropped for a gap.
    // Called right after a rising edge; returns at the edge where the transfer happens.
    task automatic push_item(input logic [1:0] kind, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(kind, data);
        burst_left--;
        items_sent++;
    endtask

    // Sender pause: wait for every owed pixel, then let the pipe settle so that
    // transfers which make no pixel have also passed through.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.awaited_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle; pready is tied high.
    task automatic write_register(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One mostly well-formed frame: start, raw pixel, then a few runs with random
    // content. Copy lookbacks lean toward distances already covered by the frame.
    // Some noise and broken runs are mixed in.
    task automatic send_random_frame(input int limit);
        longint planned;
        longint lookback_dist;
        longint w;
        int     runs;
        int     pick;
        int     n;
        int     size;
        int     sel;
        int     code;
        int     lo;
        int     hi;
        push_item(KIND_START, 8'($urandom));
        push_item(KIND_BYTE, 8'($urandom));
        planned = 1;
        runs = $urandom_range(2, 10);
        repeat (runs) begin
            if (items_sent >= limit) break;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: any kind, including the reserved one
                push_item(2'($urandom_range(0, 3)), 8'($urandom));
            end else if (pick < 45) begin
                n = $urandom_range(0, 15);
                push_item(KIND_BYTE, 8'(n));
                repeat (n + 1) push_item(KIND_BYTE, 8'($urandom));
                planned += n + 1;
            end else if (pick < 48) begin
                // long literal, cut short; the next frame start breaks it off
                lo = $urandom_range(0, 255);
                hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
                push_item(KIND_BYTE, LONG_LIT_FLAG);
                push_item(KIND_BYTE, 8'(lo));
                push_item(KIND_BYTE, 8'(hi));
                repeat (40) push_item(KIND_BYTE, 8'($urandom));
                break;
            end else begin
                w = longint'(sb.image_width);
                sel = $urandom_range(0, 15);
                for (int t = 0; t < 4; t++) begin
                    if (sel < 4) lookback_dist = sel + 1;
                    else if (sel < 11) lookback_dist = w - 3 + (sel - 4);
                    else lookback_dist = 2 * w - 2 + (sel - 11);
                    if (lookback_dist >= 1 && lookback_dist <= planned) break;
                    sel = $urandom_range(0, 15);
                end
                code = $urandom_range(0, 7);
                push_item(KIND_BYTE, {1'b1, 4'(sel), 3'(code)});
                if (code == LONG_COPY_CODE) begin
                    lo = $urandom_range(0, 30);
                    hi = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : 0;
                    push_item(KIND_BYTE, 8'(lo));
                    push_item(KIND_BYTE, 8'(hi));
                    size = hi * 256 + lo + LEN_BIAS_COPY;
                end else begin
                    size = code + COPY_SIZE_BIAS;
                end
                n = (size > 60) ? 60 : size;
                // now and then one tick short or one too many
                pick = $urandom_range(0, 9);
                if (pick == 0) n = n - 1;
                else if (pick == 1) n = n + 1;
                repeat (n) push_item(KIND_TICK, 8'($urandom));
                planned += size;
            end
        end
    endtask

    initial begin
        int limit;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_kind      <= KIND_BYTE;
        s_data_byte <= 8'h00;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= 3'd0;
        pwdata      <= 32'd0;
        burst_left  = 0;
        items_sent  = 0;
        hold_req    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // narrow image, tiny frame; raw pixel, a stray tick, a one-byte literal
        write_register(REG_IMAGE_WIDTH, 32'd4);
        write_register(REG_PIXEL_COUNT, 32'd5);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'h3C);
        // pixel count grows mid-frame; the new value applies at once
        wait_drained();
        write_register(REG_PIXEL_COUNT, 32'd8);
        // copy of 6 from distance 1, a byte dropped inside it, ends the frame exactly
        push_item(KIND_BYTE, 8'h83);
        push_item(KIND_BYTE, 8'h12);
        repeat (6) push_item(KIND_TICK, 8'hA5);
        // frame over: tick and reserved kind do nothing
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_RESERVED, 8'hFF);
        // two-row lookback with one pixel decoded: bad reference ends the frame
        push_item(KIND_START, 8'h00);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hF8);
        push_item(KIND_BYTE, 8'h05);
        // empty frame: nothing comes out
        wait_drained();
        write_register(REG_PIXEL_COUNT, 32'd0);
        push_item(KIND_START, 8'h00);
        push_item(KIND_BYTE, 8'h11);
        push_item(KIND_TICK, 8'h00);
        // widest image; longest literal run is cut off by the frame end
        wait_drained();
        write_register(REG_IMAGE_WIDTH, 32'd2047);
        write_register(REG_PIXEL_COUNT, 32'd3);
        push_item(KIND_START, 8'h00);
        push_item(KIND_BYTE, 8'h42);
        push_item(KIND_BYTE, LONG_LIT_FLAG);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'h01);
        push_item(KIND_BYTE, 8'h02);
        push_item(KIND_BYTE, 8'h00);
        wait_drained();

        // ---- random part: one register setting per phase, extremes included ----
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin
                    write_register(REG_IMAGE_WIDTH, 32'd4);
                    write_register(REG_PIXEL_COUNT, $urandom_range(40, 200));
                end
                1: begin
                    write_register(REG_IMAGE_WIDTH, 32'd2047);
                    write_register(REG_PIXEL_COUNT, $urandom_range(40, 200));
                end
                2: begin
                    write_register(REG_IMAGE_WIDTH, $urandom_range(5, 40));
                    write_register(REG_PIXEL_COUNT, 32'd1);
                end
                3: begin
                    write_register(REG_IMAGE_WIDTH, $urandom_range(5, 40));
                    write_register(REG_PIXEL_COUNT, 32'hFFFF_FFFF);
                end
                4: begin
                    // width 0 brings row lookbacks down to -3..3, many of them zero or below
                    write_register(REG_IMAGE_WIDTH, 32'd0);
                    write_register(REG_PIXEL_COUNT, $urandom_range(20, 250));
                end
                default: begin
                    write_register(REG_IMAGE_WIDTH, $urandom_range(4, 64));
                    write_register(REG_PIXEL_COUNT, $urandom_range(20, 250));
                end
            endcase
            // one long receiver hold-off while the sender keeps going
            if (p == 5) hold_req = 1;
            limit = items_sent + PHASE_ITEMS;
            while (items_sent < limit) send_random_frame(limit);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_pixels.size() == 0) begin
            $display("lz_2d_offset_image_decompressor_test: done, clean");
        end else begin
            $display("lz_2d_offset_image_decompressor_test: done, errors");
        end
        $finish;
    end

endmodule
